@@ hw/rtl/rra_pkg.sv @@
package rra_pkg;

  // default size of the sequence number space
  localparam int SEQ_SPACE_DEF = 12;

  // largest usable receive window and its reset value
  localparam int         MAX_WINDOW   = 6;
  localparam logic [2:0] WINDOW_RESET = 3'd6;

  // configuration port
  localparam int         ADDR_W     = 3;
  localparam int         DATA_W     = 32;
  localparam logic [0:0] CFG_WINDOW = 1'b0;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  // ack packet: twenty '0' characters, and their byte sum
  localparam logic [63:0] ZERO_WORD = 64'h3030_3030_3030_3030;
  localparam logic [9:0]  ACK_BASE  = 10'd960;

  // controller to datapath
  typedef struct packed {
    logic capture;  // register the incoming packet
    logic psum;     // register partial byte sums
    logic check;    // finish checksum, store the packet if it qualifies
    logic deliver;  // load one held payload into the output register
    logic ack;      // load the ack result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;       // another in-order payload is ready to go out
    logic slot_free;  // output register can take a result this cycle
  } status_t;

  // sum of the eight bytes of a word, each taken as signed
  function automatic logic signed [11:0] byte_sum(input logic [63:0] word);
    logic signed [11:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc = acc + 12'(signed'(word[8*k +: 8]));
    end
    return acc;
  endfunction

endpackage

@@ hw/rtl/rra_pkt_if.sv @@
interface rra_pkt_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] seq_num;
  logic signed [15:0] ack_num;
  logic signed [31:0] check_value;
  logic [63:0]        payload_low;
  logic [63:0]        payload_mid;
  logic [31:0]        payload_high;

  modport source (
    output valid, seq_num, ack_num, check_value, payload_low, payload_mid, payload_high,
    input  ready
  );
  modport sink (
    input  valid, seq_num, ack_num, check_value, payload_low, payload_mid, payload_high,
    output ready
  );
endinterface

@@ hw/rtl/rra_res_if.sv @@
interface rra_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [3:0]  ack_number;
  logic        ack_sequence;
  logic [9:0]  ack_checksum;
  logic [63:0] out_payload_low;
  logic [63:0] out_payload_mid;
  logic [31:0] out_payload_high;
  logic        last;

  modport source (
    output valid, result_kind, ack_number, ack_sequence, ack_checksum,
           out_payload_low, out_payload_mid, out_payload_high, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, ack_number, ack_sequence, ack_checksum,
           out_payload_low, out_payload_mid, out_payload_high, last,
    output ready
  );
endinterface

@@ hw/rtl/rra_ctrl.sv @@
module rra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rra_pkg::status_t  status,
  output rra_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_CHECK,
    S_DELIV
  } state_t;

  state_t state;
  state_t state_next;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SUM;
        end
      end
      S_SUM: begin
        cmd.psum   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_DELIV;
      end
      S_DELIV: begin
        // one result per free output slot; the ack closes the transaction
        if (status.slot_free) begin
          if (status.more) begin
            cmd.deliver = 1'b1;
          end else begin
            cmd.ack    = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/rra_datapath.sv @@
module rra_datapath #(
  parameter int SEQ_SPACE = rra_pkg::SEQ_SPACE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rra_pkg::cmd_t               cmd,
  output rra_pkg::status_t            status,
  // configuration
  input  logic                        cfg_wr,
  input  logic [2:0]                  cfg_wdata,
  output logic [2:0]                  cfg_window,
  // packet fields
  input  logic signed [15:0]          seq_num,
  input  logic signed [15:0]          ack_num,
  input  logic signed [31:0]          check_value,
  input  logic [63:0]                 payload_low,
  input  logic [63:0]                 payload_mid,
  input  logic [31:0]                 payload_high,
  // result register
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        result_kind,
  output logic [3:0]                  ack_number,
  output logic                        ack_sequence,
  output logic [9:0]                  ack_checksum,
  output logic [63:0]                 out_payload_low,
  output logic [63:0]                 out_payload_mid,
  output logic [31:0]                 out_payload_high,
  output logic                        last
);

  localparam int IW = $clog2(SEQ_SPACE);
  localparam int PW = 160;

  // captured packet
  logic signed [15:0] seq_r;
  logic signed [15:0] ack_r;
  logic signed [31:0] chk_r;
  logic [PW-1:0]      pay_r;

  // partial sums
  logic signed [11:0] sum_lo;
  logic signed [11:0] sum_mid;
  logic signed [17:0] sum_hi;

  // receiver state
  logic              window;
  logic [2:0]        window_reg;
  logic              held [SEQ_SPACE];
  logic [IW-1:0]     expected;
  logic              toggle;
  logic              intact;
  logic [2:0]        dcount;
  logic [PW-1:0]     store_mem [SEQ_SPACE];
  logic [PW-1:0]     rd_data;

  // check-cycle terms
  logic signed [18:0] total;
  logic               intact_now;
  logic               seq_ok;
  logic [IW-1:0]      slot;
  logic [IW:0]        diff;
  logic [IW:0]        offset;
  logic [2:0]         win;
  logic               store_en;
  logic [IW-1:0]      expected_inc;
  logic [IW-1:0]      ack_cur;

  assign window     = 1'b0;
  assign cfg_window = window_reg | {2'b0, window};

  // receive window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg <= rra_pkg::WINDOW_RESET;
    end else if (cfg_wr) begin
      window_reg <= cfg_wdata;
    end
  end

  // packet capture and partial sums
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_r <= seq_num;
      ack_r <= ack_num;
      chk_r <= check_value;
      pay_r <= {payload_high, payload_mid, payload_low};
    end
    if (cmd.psum) begin
      sum_lo  <= rra_pkg::byte_sum(pay_r[63:0]);
      sum_mid <= rra_pkg::byte_sum(pay_r[127:64]);
      sum_hi  <= 18'(seq_r) + 18'(ack_r) + 18'(rra_pkg::byte_sum(64'(pay_r[159:128])));
    end
  end

  // checksum compare and store qualification
  always_comb begin
    total      = 19'(sum_hi) + 19'(sum_lo) + 19'(sum_mid);
    intact_now = (32'(total) == chk_r);
    seq_ok     = !seq_r[15] && (seq_r[14:0] < 15'(SEQ_SPACE));
    slot       = seq_r[IW-1:0];
    diff       = {1'b0, slot} - {1'b0, expected};
    offset     = diff[IW] ? diff + (IW+1)'(SEQ_SPACE) : diff;
    win        = (window_reg > 3'(rra_pkg::MAX_WINDOW)) ? 3'(rra_pkg::MAX_WINDOW) : window_reg;
    store_en   = intact_now && seq_ok && (9'(offset) < 9'(win)) && !held[slot];
  end

  assign expected_inc = (expected == IW'(SEQ_SPACE - 1)) ? '0 : expected + 1'b1;
  assign ack_cur      = (expected == '0) ? IW'(SEQ_SPACE - 1) : expected - 1'b1;

  assign status.more      = intact && held[expected] && (dcount < 3'(rra_pkg::MAX_WINDOW));
  assign status.slot_free = !out_valid || out_ready;

  // payload store
  always_ff @(posedge clk) begin
    if (cmd.check && store_en) begin
      store_mem[slot] <= pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      rd_data <= store_mem[expected];
    end
  end

  // held flags, expected number, delivery count, ack toggle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEQ_SPACE; i++) begin
        held[i] <= 1'b0;
      end
      expected <= '0;
      toggle   <= 1'b1;
      intact   <= 1'b0;
      dcount   <= '0;
    end else begin
      if (cmd.check) begin
        intact <= intact_now;
        dcount <= '0;
        if (store_en) begin
          held[slot] <= 1'b1;
        end
      end
      if (cmd.deliver) begin
        held[expected] <= 1'b0;
        expected       <= expected_inc;
        dcount         <= dcount + 1'b1;
      end
      if (cmd.ack) begin
        toggle <= ~toggle;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver || cmd.ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      result_kind  <= rra_pkg::KIND_DATA;
      ack_number   <= '0;
      ack_sequence <= 1'b0;
      ack_checksum <= '0;
      last         <= 1'b0;
    end else if (cmd.ack) begin
      result_kind  <= rra_pkg::KIND_ACK;
      ack_number   <= 4'(ack_cur);
      ack_sequence <= toggle;
      ack_checksum <= rra_pkg::ACK_BASE + 10'(ack_cur) + 10'(toggle);
      last         <= 1'b1;
    end
  end

  // ack results carry the '0' character payload
  assign out_payload_low  = (result_kind == rra_pkg::KIND_ACK) ? rra_pkg::ZERO_WORD
                                                               : rd_data[63:0];
  assign out_payload_mid  = (result_kind == rra_pkg::KIND_ACK) ? rra_pkg::ZERO_WORD
                                                               : rd_data[127:64];
  assign out_payload_high = (result_kind == rra_pkg::KIND_ACK) ? rra_pkg::ZERO_WORD[31:0]
                                                               : rd_data[159:128];

endmodule

@@ hw/rtl/reorder_receiver_with_ack.sv @@
// Reordering receiver with cumulative acknowledgement.
// The pkt channel takes one data packet per transaction: sequence number, ack
// field, checksum and twenty payload bytes. The res channel returns, for every
// packet, zero to six in-order payload deliveries and then one ack result with
// last set. Packets that fail the checksum only produce the ack.
// Timing: the packet is registered at acceptance, partial byte sums are
// registered in S_SUM and the checksum compare plus store run in S_CHECK;
// results are then loaded into the output register from S_DELIV. No new
// packet is taken until the ack of the current one has been loaded; the
// controller steps one result per cycle through the output register and the
// single read port of the payload store while the output register is free.
// A stalled res channel holds the output register and pauses delivery; the
// last result may wait in that register while a new packet is accepted.
// Reset clears the held flags, sets the expected number to zero, the ack
// sequence bit to one and the receive window to six; no clearing pass is run.
// The receive window register sits at address 0 of the APB port.
module reorder_receiver_with_ack #(
  parameter int SEQ_SPACE = rra_pkg::SEQ_SPACE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  rra_pkt_if.sink                     pkt,
  rra_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rra_pkg::ADDR_W-1:0]  paddr,
  input  logic [rra_pkg::DATA_W-1:0]  pwdata,
  output logic [rra_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  rra_pkg::cmd_t    cmd;
  rra_pkg::status_t status;
  logic             cfg_wr;
  logic [2:0]       cfg_window;

  // register decode: only the window register exists
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rra_pkg::CFG_WINDOW);
  assign prdata = (paddr[2] == rra_pkg::CFG_WINDOW) ? {29'b0, cfg_window} : '0;

  rra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt.valid),
    .in_ready (pkt.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rra_datapath #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr           (cfg_wr),
    .cfg_wdata        (pwdata[2:0]),
    .cfg_window       (cfg_window),
    .seq_num          (pkt.seq_num),
    .ack_num          (pkt.ack_num),
    .check_value      (pkt.check_value),
    .payload_low      (pkt.payload_low),
    .payload_mid      (pkt.payload_mid),
    .payload_high     (pkt.payload_high),
    .out_valid        (res.valid),
    .out_ready        (res.ready),
    .result_kind      (res.result_kind),
    .ack_number       (res.ack_number),
    .ack_sequence     (res.ack_sequence),
    .ack_checksum     (res.ack_checksum),
    .out_payload_low  (res.out_payload_low),
    .out_payload_mid  (res.out_payload_mid),
    .out_payload_high (res.out_payload_high),
    .last             (res.last)
  );

endmodule
